// ----- rtl/core/mbq_pkg.sv -----
// Package for the DSP-to-CPU mailbox queue.
// Holds queue sizing, function codes and controller/datapath interface structs.
// No dependencies.
package mbq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int MAIL_W      = 32;
   localparam int HALF_W      = 16;

   typedef enum logic [2:0] {
      FUNC_PUSH      = 3'd0,
      FUNC_READ_HIGH = 3'd1,
      FUNC_READ_LOW  = 3'd2,
      FUNC_CLEAR     = 3'd3,
      FUNC_SET_HALT  = 3'd4
   } func_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the incoming transaction
      logic commit;    // apply the update and load the response register
   } cmd_type;

   // datapath -> checks
   typedef struct packed {
      logic pending;   // queue non-empty
      logic full;      // queue holds QUEUE_DEPTH mails
   } status_type;

endpackage

// ----- rtl/core/dsp_to_cpu_mailbox_queue_unit.sv -----
// DSP-to-CPU mailbox queue, top level. The accept edge captures the request
// and registers the RAM head read (state IDLE); execute (state EXEC) then
// applies the update and sets response valid, held while a response still
// waits in the output register. A request is taken only in IDLE, so the block
// takes no new request before the last one has executed; with a response
// waiting, one more request is taken and the next waits. Reset (synchronous)
// empties the queue and clears last-mail and halted; mail RAM stays undefined.
module dsp_to_cpu_mailbox_queue_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_func,
   input  logic [mbq_pkg::MAIL_W-1:0]    req_mail_word,
   input  logic                          req_want_interrupt,
   input  logic [mbq_pkg::HALF_W-1:0]    req_irq_delay,
   input  logic                          req_halt_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mbq_pkg::HALF_W-1:0]    rsp_read_half,
   output logic                          rsp_raise_irq,
   output logic [mbq_pkg::HALF_W-1:0]    rsp_raise_irq_delay,
   output logic                          rsp_has_pending,
   output logic                          rsp_push_dropped
);

   mbq_pkg::cmd_type    cmd;
   mbq_pkg::status_type status;

   mbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mbq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_func            (req_func),
      .req_mail_word       (req_mail_word),
      .req_want_interrupt  (req_want_interrupt),
      .req_irq_delay       (req_irq_delay),
      .req_halt_value      (req_halt_value),
      .rsp_read_half       (rsp_read_half),
      .rsp_raise_irq       (rsp_raise_irq),
      .rsp_raise_irq_delay (rsp_raise_irq_delay),
      .rsp_has_pending     (rsp_has_pending),
      .rsp_push_dropped    (rsp_push_dropped)
   );

   a_capture_commit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

   a_pending_tracks_count: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_has_pending == status.pending))
      else $error("has_pending disagrees with queue occupancy");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !status.full) |=> !rsp_push_dropped)
      else $error("push dropped while queue not full");

   a_delay_needs_irq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_raise_irq_delay != '0)) |-> rsp_raise_irq)
      else $error("interrupt delay without interrupt");

endmodule

// ----- rtl/core/mbq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/mbq_datapath.sv -----
// Mailbox queue datapath: captured transaction, queue pointers, last-mail,
// halted flag, per-entry pop flags, mail RAM and response registers.
// Depends on mbq_pkg and mbq_ram.
module mbq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mbq_pkg::cmd_type              cmd,
   output mbq_pkg::status_type           status,
   input  logic [2:0]                    req_func,
   input  logic [mbq_pkg::MAIL_W-1:0]    req_mail_word,
   input  logic                          req_want_interrupt,
   input  logic [mbq_pkg::HALF_W-1:0]    req_irq_delay,
   input  logic                          req_halt_value,
   output logic [mbq_pkg::HALF_W-1:0]    rsp_read_half,
   output logic                          rsp_raise_irq,
   output logic [mbq_pkg::HALF_W-1:0]    rsp_raise_irq_delay,
   output logic                          rsp_has_pending,
   output logic                          rsp_push_dropped
);

   localparam int IW = mbq_pkg::IDX_W;
   localparam int CW = mbq_pkg::CNT_W;
   localparam int MW = mbq_pkg::MAIL_W;
   localparam int HW = mbq_pkg::HALF_W;
   localparam int D  = mbq_pkg::QUEUE_DEPTH;

   // captured transaction
   logic [2:0]    func_ff;
   logic [MW-1:0] mail_ff;
   logic          want_ff;
   logic [HW-1:0] delay_ff;
   logic          halt_ff;

   // queue state
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [MW-1:0] last_ff, last_in;
   logic          halted_ff, halted_in;
   logic [D-1:0]  flags_ff, flags_in;

   // response registers
   logic [HW-1:0] half_ff, half_in;
   logic          irq_ff, irq_in;
   logic [HW-1:0] irq_dly_ff, irq_dly_in;
   logic          pend_ff;
   logic          drop_ff, drop_in;

   logic [MW-1:0] head_mail;
   logic          ram_wr_en;
   logic [CW:0]   tail_sum;
   logic [IW-1:0] tail_idx;
   logic [IW-1:0] head_next;
   logic          can_read;
   logic          full;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         mail_ff  <= req_mail_word;
         want_ff  <= req_want_interrupt;
         delay_ff <= req_irq_delay;
         halt_ff  <= req_halt_value;
      end
   end

   // RAM read runs every cycle at the head; data is ready the cycle after capture
   mbq_ram #(
      .WIDTH (MW),
      .DEPTH (D)
   ) u_mail_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_idx),
      .wr_data (mail_ff),
      .rd_addr (head_ff),
      .rd_data (head_mail)
   );

   assign full     = (count_ff == CW'(D));
   assign can_read = !halted_ff && (count_ff != '0);
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail_idx = (tail_sum >= (CW+1)'(D)) ? IW'(tail_sum - (CW+1)'(D)) : IW'(tail_sum);
   assign head_next = (head_ff == IW'(D - 1)) ? '0 : head_ff + IW'(1);

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      halted_in  = halted_ff;
      flags_in   = flags_ff;
      half_in    = '0;
      irq_in     = 1'b0;
      irq_dly_in = '0;
      drop_in    = 1'b0;
      ram_wr_en  = 1'b0;
      case (func_ff)
         mbq_pkg::FUNC_PUSH: begin
            if (full) begin
               drop_in = 1'b1;
            end else begin
               if (want_ff) begin
                  if (count_ff == '0) begin
                     irq_in     = 1'b1;
                     irq_dly_in = delay_ff;
                  end else begin
                     flags_in[head_ff] = 1'b1;
                  end
               end
               flags_in[tail_idx] = 1'b0;
               ram_wr_en          = cmd.commit;
               count_in           = count_ff + CW'(1);
            end
         end
         mbq_pkg::FUNC_READ_HIGH: begin
            if (can_read) begin
               last_in = head_mail;
            end
            half_in = last_in[MW-1:HW];
         end
         mbq_pkg::FUNC_READ_LOW: begin
            if (can_read) begin
               last_in  = head_mail;
               irq_in   = flags_ff[head_ff];
               head_in  = head_next;
               count_in = count_ff - CW'(1);
            end
            last_in[MW-1] = 1'b0;
            half_in       = last_in[HW-1:0];
         end
         mbq_pkg::FUNC_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         mbq_pkg::FUNC_SET_HALT: begin
            halted_in = halt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         last_ff   <= '0;
         halted_ff <= 1'b0;
      end else if (cmd.commit) begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         last_ff   <= last_in;
         halted_ff <= halted_in;
      end
   end

   // pop flags are only read for occupied entries, so no reset
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         flags_ff   <= flags_in;
         half_ff    <= half_in;
         irq_ff     <= irq_in;
         irq_dly_ff <= irq_dly_in;
         pend_ff    <= (count_in != '0);
         drop_ff    <= drop_in;
      end
   end

   assign status.pending = (count_ff != '0);
   assign status.full    = full;

   assign rsp_read_half       = half_ff;
   assign rsp_raise_irq       = irq_ff;
   assign rsp_raise_irq_delay = irq_dly_ff;
   assign rsp_has_pending     = pend_ff;
   assign rsp_push_dropped    = drop_ff;

endmodule

// ----- rtl/core/mbq_ctrl.sv -----
// Mailbox queue controller: request handshake, execute sequencing and
// response valid. Depends on mbq_pkg.
module mbq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mbq_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready   = (state_ff == ST_IDLE);
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_EXEC) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait here until the response register can take the result
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
